// ===== rtl/acfrb_pkg.sv =====
// Shared package for the audio codec register block.
// Holds operation and register codes, field widths and the structs that
// pass between the FIFO, register and top-level modules. No dependencies.
package acfrb_pkg;

  // Field widths of one bus or converter word.
  localparam int unsigned OpW     = 3;
  localparam int unsigned SelW    = 3;
  localparam int unsigned DataW   = 16;
  localparam int unsigned FlagW   = 5;
  localparam int unsigned PowerW  = 3;
  localparam int unsigned AdcCtlW = 11;

  // Operation codes.
  localparam logic [OpW-1:0] OP_BUS_READ  = 3'd0;
  localparam logic [OpW-1:0] OP_BUS_WRITE = 3'd1;
  localparam logic [OpW-1:0] OP_ADC_PUSH  = 3'd2;
  localparam logic [OpW-1:0] OP_DAC_PULL  = 3'd3;
  localparam logic [OpW-1:0] OP_OVERCURR  = 3'd4;

  // Register select codes.
  localparam logic [SelW-1:0] REG_POWER    = 3'd0;
  localparam logic [SelW-1:0] REG_MASK     = 3'd1;
  localparam logic [SelW-1:0] REG_ADC_CTL  = 3'd2;
  localparam logic [SelW-1:0] REG_DAC_CTL  = 3'd3;
  localparam logic [SelW-1:0] REG_FLAGS    = 3'd4;
  localparam logic [SelW-1:0] REG_ADC_DATA = 3'd5;
  localparam logic [SelW-1:0] REG_DAC_DATA = 3'd6;

  // Power register bits.
  localparam int unsigned PWR_ADC_EN = 0;
  localparam int unsigned PWR_DAC_EN = 1;

  // Flag register bits that clear a sticky flag on a write of one.
  localparam int unsigned FLG_DAC_UNF = 0;
  localparam int unsigned FLG_ADC_OVF = 1;
  localparam int unsigned FLG_OVERCUR = 4;

  // Request into one sample FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

  // Status of one sample FIFO.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // Events that set sticky flags.
  typedef struct packed {
    logic overcurrent;
    logic adc_overflow;
    logic dac_underflow;
  } flag_evt_t;

endpackage

// ===== rtl/audio_codec_fifo_register_block_core.sv =====
// Audio codec register block: top level with the sequencer and output word.
// Instantiates acfrb_regs and two acfrb_fifo; depends on acfrb_pkg.
//
// Each input word is one bus access or converter event and gives exactly one
// output word. After acceptance a word passes the execute state, which updates
// registers and issues the FIFO memory access, and then the finish state, which
// waits for a free output and loads the output register from the memory read.
// A new word is accepted only once the previous one has left the sequencer,
// so the block does not take a new word while one is still in flight.
// The ADC and DAC sample FIFOs are synchronous memories of ADC_FIFO_DEPTH and
// DAC_FIFO_DEPTH entries; they need no clearing after reset.
module audio_codec_fifo_register_block_core #(
  parameter int unsigned ADC_FIFO_DEPTH = 16,
  parameter int unsigned DAC_FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // write_value [15:0], adc_sample [31:16]
  input  logic [31:0] s_tdata,
  // operation [2:0], reg_select [5:3]
  input  logic [5:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_value [15:0], dac_sample [31:16], irq_line [32], zero [39:33]
  output logic [39:0] m_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_t;

  state_t                        state;
  logic [acfrb_pkg::OpW-1:0]     op;
  logic [acfrb_pkg::SelW-1:0]    sel;
  logic [acfrb_pkg::DataW-1:0]   wval;
  logic [acfrb_pkg::DataW-1:0]   smp;
  logic                          hit;
  logic                          hit_next;

  acfrb_pkg::fifo_req_t          adc_req;
  acfrb_pkg::fifo_req_t          dac_req;
  acfrb_pkg::fifo_stat_t         adc_stat;
  acfrb_pkg::fifo_stat_t         dac_stat;
  acfrb_pkg::flag_evt_t          evt;
  logic [acfrb_pkg::DataW-1:0]   adc_rdata;
  logic [acfrb_pkg::DataW-1:0]   dac_rdata;
  logic [acfrb_pkg::PowerW-1:0]  power;
  logic [acfrb_pkg::DataW-1:0]   reg_rd;
  logic                          irq;
  logic                          reg_wr;
  logic [acfrb_pkg::DataW-1:0]   read_value;
  logic [acfrb_pkg::DataW-1:0]   dac_sample;
  logic                          out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Execute step: FIFO requests, register write and flag events.
  always_comb begin
    adc_req  = '0;
    dac_req  = '0;
    evt      = '0;
    reg_wr   = 1'b0;
    hit_next = 1'b0;
    if (state == ST_EXEC) begin
      unique case (op)
        acfrb_pkg::OP_BUS_READ: begin
          if (sel == acfrb_pkg::REG_ADC_DATA && !adc_stat.empty) begin
            adc_req.pop = 1'b1;
            hit_next    = 1'b1;
          end
        end
        acfrb_pkg::OP_BUS_WRITE: begin
          reg_wr = 1'b1;
          if (sel == acfrb_pkg::REG_DAC_DATA && !dac_stat.full) begin
            dac_req.push = 1'b1;
          end
        end
        acfrb_pkg::OP_ADC_PUSH: begin
          if (power[acfrb_pkg::PWR_ADC_EN]) begin
            adc_req.push     = !adc_stat.full;
            evt.adc_overflow = adc_stat.full;
          end
        end
        acfrb_pkg::OP_DAC_PULL: begin
          if (power[acfrb_pkg::PWR_DAC_EN]) begin
            dac_req.pop       = !dac_stat.empty;
            hit_next          = !dac_stat.empty;
            evt.dac_underflow = dac_stat.empty;
          end
        end
        acfrb_pkg::OP_OVERCURR: begin
          evt.overcurrent = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields, formed after the state update has landed.
  always_comb begin
    read_value = '0;
    dac_sample = '0;
    if (op == acfrb_pkg::OP_BUS_READ) begin
      read_value = (sel == acfrb_pkg::REG_ADC_DATA) ? (hit ? adc_rdata : '0) : reg_rd;
    end
    if (op == acfrb_pkg::OP_DAC_PULL && hit) begin
      dac_sample = dac_rdata;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // A finished word loads the output; otherwise a taken word clears it.
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Captured word and payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op   <= s_tuser[2:0];
      sel  <= s_tuser[5:3];
      wval <= s_tdata[15:0];
      smp  <= s_tdata[31:16];
    end
    if (state == ST_EXEC) begin
      hit <= hit_next;
    end
    if (state == ST_FIN && out_free) begin
      m_tdata <= {7'd0, irq, dac_sample, read_value};
    end
  end

  acfrb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (reg_wr),
    .sel      (sel),
    .wdata    (wval),
    .evt      (evt),
    .adc_stat (adc_stat),
    .dac_stat (dac_stat),
    .power    (power),
    .rd_data  (reg_rd),
    .irq      (irq)
  );

  acfrb_fifo #(
    .DEPTH (ADC_FIFO_DEPTH)
  ) u_adc_fifo (
    .clk   (clk),
    .rst   (rst),
    .req   (adc_req),
    .wdata (smp),
    .rdata (adc_rdata),
    .stat  (adc_stat)
  );

  acfrb_fifo #(
    .DEPTH (DAC_FIFO_DEPTH)
  ) u_dac_fifo (
    .clk   (clk),
    .rst   (rst),
    .req   (dac_req),
    .wdata (wval),
    .rdata (dac_rdata),
    .stat  (dac_stat)
  );

endmodule

// ===== rtl/acfrb_fifo.sv =====
// Sample FIFO built around one synchronous memory with a registered read.
// Keeps head, tail and fill count; depends on acfrb_pkg for its structs.
module acfrb_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  acfrb_pkg::fifo_req_t        req,
  input  logic [acfrb_pkg::DataW-1:0] wdata,
  output logic [acfrb_pkg::DataW-1:0] rdata,
  output acfrb_pkg::fifo_stat_t       stat
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [acfrb_pkg::DataW-1:0] mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (req.push) begin
        tail <= (tail == LastIdx) ? '0 : tail + AW'(1);
      end
      if (req.pop) begin
        head <= (head == LastIdx) ? '0 : head + AW'(1);
      end
      unique case ({req.push, req.pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // Sample storage; read data holds until the next pop.
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail] <= wdata;
    end
    if (req.pop) begin
      rdata <= mem[head];
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

endmodule

// ===== rtl/acfrb_regs.sv =====
// Control and status registers: power, mask, converter controls, sticky
// flags, bus read selection and the interrupt. Depends on acfrb_pkg.
module acfrb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [acfrb_pkg::SelW-1:0]   sel,
  input  logic [acfrb_pkg::DataW-1:0]  wdata,
  input  acfrb_pkg::flag_evt_t         evt,
  input  acfrb_pkg::fifo_stat_t        adc_stat,
  input  acfrb_pkg::fifo_stat_t        dac_stat,
  output logic [acfrb_pkg::PowerW-1:0] power,
  output logic [acfrb_pkg::DataW-1:0]  rd_data,
  output logic                         irq
);

  typedef acfrb_pkg::flag_evt_t flag_clr_t;

  logic [acfrb_pkg::FlagW-1:0]   mask;
  logic [acfrb_pkg::AdcCtlW-1:0] adc_ctl;
  logic [acfrb_pkg::DataW-1:0]   dac_ctl;
  flag_clr_t                     sticky;
  logic [acfrb_pkg::FlagW-1:0]   flags;

  // Register writes and sticky flag updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      power   <= '0;
      mask    <= '0;
      adc_ctl <= '0;
      dac_ctl <= '0;
      sticky  <= '0;
    end else begin
      if (wr_en && sel == acfrb_pkg::REG_POWER) begin
        power <= wdata[acfrb_pkg::PowerW-1:0];
      end
      if (wr_en && sel == acfrb_pkg::REG_MASK) begin
        mask <= wdata[acfrb_pkg::FlagW-1:0];
      end
      if (wr_en && sel == acfrb_pkg::REG_ADC_CTL) begin
        adc_ctl <= wdata[acfrb_pkg::AdcCtlW-1:0];
      end
      if (wr_en && sel == acfrb_pkg::REG_DAC_CTL) begin
        dac_ctl <= wdata;
      end
      if (wr_en && sel == acfrb_pkg::REG_FLAGS) begin
        sticky.dac_underflow <= sticky.dac_underflow & ~wdata[acfrb_pkg::FLG_DAC_UNF];
        sticky.adc_overflow  <= sticky.adc_overflow & ~wdata[acfrb_pkg::FLG_ADC_OVF];
        sticky.overcurrent   <= sticky.overcurrent & ~wdata[acfrb_pkg::FLG_OVERCUR];
      end else begin
        sticky <= sticky | evt;
      end
    end
  end

  // Flag word: sticky bits plus live FIFO status.
  assign flags = {sticky.overcurrent, ~dac_stat.full, ~adc_stat.empty,
                  sticky.adc_overflow, sticky.dac_underflow};

  // Bus read selection for the plain registers.
  always_comb begin
    unique case (sel)
      acfrb_pkg::REG_POWER:   rd_data = acfrb_pkg::DataW'(power);
      acfrb_pkg::REG_MASK:    rd_data = acfrb_pkg::DataW'(mask);
      acfrb_pkg::REG_ADC_CTL: rd_data = acfrb_pkg::DataW'(adc_ctl);
      acfrb_pkg::REG_DAC_CTL: rd_data = dac_ctl;
      acfrb_pkg::REG_FLAGS:   rd_data = acfrb_pkg::DataW'(flags);
      default:                rd_data = '0;
    endcase
  end

  assign irq = |(flags & mask);

endmodule

// ===== tb/acfrb_codec_word_chk.sv =====
// Checker for the audio codec register block: watches both streams, predicts
// each output word from the accepted input words and compares them field by field.
// Depends on acfrb_pkg for the operation, register and flag codes.
`timescale 1ns / 100ps

module acfrb_codec_word_chk
  import acfrb_pkg::*;
#(
  parameter int unsigned ADC_DEPTH = 16,
  parameter int unsigned DAC_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // write_value [15:0], adc_sample [31:16]
  input  logic [31:0] s_tdata,
  // operation [2:0], reg_select [5:3]
  input  logic [5:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // read_value [15:0], dac_sample [31:16], irq_line [32], zero [39:33]
  input  logic [39:0] m_tdata,
  output int unsigned fail_count,
  output int unsigned words_pending
);

  // Live status bits of the flag register.
  localparam int unsigned FLG_ADC_NE = 2;
  localparam int unsigned FLG_DAC_NF = 3;

  // One output word, laid out as on m_tdata.
  typedef struct packed {
    logic [6:0]       pad;
    logic             irq;
    logic [DataW-1:0] dac;
    logic [DataW-1:0] rd;
  } codec_out_t;

  codec_out_t expected_words[$];

  // Predicted register and FIFO contents.
  logic [DataW-1:0]   adc_samples[$];
  logic [DataW-1:0]   dac_samples[$];
  logic [PowerW-1:0]  power_reg;
  logic [FlagW-1:0]   mask_reg;
  logic [AdcCtlW-1:0] adc_ctl_reg;
  logic [DataW-1:0]   dac_ctl_reg;
  logic               dac_unf;
  logic               adc_ovf;
  logic               overcur;

  // Flag register as a bus read would see it.
  function automatic logic [FlagW-1:0] flag_word();
    logic [FlagW-1:0] f;
    f = '0;
    f[FLG_DAC_UNF] = dac_unf;
    f[FLG_ADC_OVF] = adc_ovf;
    f[FLG_OVERCUR] = overcur;
    f[FLG_ADC_NE]  = (adc_samples.size() != 0);
    f[FLG_DAC_NF]  = (dac_samples.size() < DAC_DEPTH);
    return f;
  endfunction

  // Apply one bus access or converter event and work out its output word.
  task automatic predict_codec_word(input logic [OpW-1:0] op, input logic [SelW-1:0] sel,
                                    input logic [DataW-1:0] wv, input logic [DataW-1:0] smp,
                                    output codec_out_t res);
    res = '0;
    case (op)
      OP_BUS_READ: begin
        case (sel)
          REG_POWER:    res.rd = DataW'(power_reg);
          REG_MASK:     res.rd = DataW'(mask_reg);
          REG_ADC_CTL:  res.rd = DataW'(adc_ctl_reg);
          REG_DAC_CTL:  res.rd = dac_ctl_reg;
          REG_FLAGS:    res.rd = DataW'(flag_word());
          REG_ADC_DATA: begin
            if (adc_samples.size() != 0) res.rd = adc_samples.pop_front();
          end
          default: ;
        endcase
      end
      OP_BUS_WRITE: begin
        case (sel)
          REG_POWER:   power_reg = wv[PowerW-1:0];
          REG_MASK:    mask_reg = wv[FlagW-1:0];
          REG_ADC_CTL: adc_ctl_reg = wv[AdcCtlW-1:0];
          REG_DAC_CTL: dac_ctl_reg = wv;
          REG_FLAGS: begin
            // Writing one clears a sticky flag; live bits ignore writes.
            if (wv[FLG_DAC_UNF]) dac_unf = 1'b0;
            if (wv[FLG_ADC_OVF]) adc_ovf = 1'b0;
            if (wv[FLG_OVERCUR]) overcur = 1'b0;
          end
          REG_DAC_DATA: begin
            if (dac_samples.size() < DAC_DEPTH) dac_samples.push_back(wv);
          end
          default: ;
        endcase
      end
      OP_ADC_PUSH: begin
        if (power_reg[PWR_ADC_EN]) begin
          if (adc_samples.size() < ADC_DEPTH) adc_samples.push_back(smp);
          else adc_ovf = 1'b1;
        end
      end
      OP_DAC_PULL: begin
        if (power_reg[PWR_DAC_EN]) begin
          if (dac_samples.size() != 0) res.dac = dac_samples.pop_front();
          else dac_unf = 1'b1;
        end
      end
      OP_OVERCURR: overcur = 1'b1;
      default: ;
    endcase
    res.irq = |(flag_word() & mask_reg);
  endtask

  // Compare output words first, then record the prediction for a new input word.
  always @(posedge clk) begin
    codec_out_t got;
    codec_out_t want;
    if (rst) begin
      adc_samples.delete();
      dac_samples.delete();
      expected_words.delete();
      power_reg   = '0;
      mask_reg    = '0;
      adc_ctl_reg = '0;
      dac_ctl_reg = '0;
      dac_unf     = 1'b0;
      adc_ovf     = 1'b0;
      overcur     = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = codec_out_t'(m_tdata);
        if (expected_words.size() == 0) begin
          $error("output word %h arrived with nothing expected", m_tdata);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.rd !== want.rd) begin
            $error("read_value: expected %h, got %h", want.rd, got.rd);
            fail_count++;
          end
          if (got.dac !== want.dac) begin
            $error("dac_sample: expected %h, got %h", want.dac, got.dac);
            fail_count++;
          end
          if (got.irq !== want.irq) begin
            $error("irq_line: expected %b, got %b", want.irq, got.irq);
            fail_count++;
          end
          if (got.pad !== want.pad) begin
            $error("zero padding: expected %h, got %h", want.pad, got.pad);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_codec_word(s_tuser[OpW-1:0], s_tuser[OpW+SelW-1:OpW], s_tdata[DataW-1:0],
                           s_tdata[2*DataW-1:DataW], want);
        expected_words.push_back(want);
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

// ===== tb/audio_codec_fifo_register_block_core_tb.sv =====
// Testbench top for the audio codec register block: clock, reset, stimulus
// and receiver stalls. Depends on acfrb_pkg and acfrb_codec_word_chk.
`timescale 1ns / 100ps

module audio_codec_fifo_register_block_core_tb;
  import acfrb_pkg::*;

  localparam int unsigned FifoDepth     = 16;
  localparam int unsigned RandomWords   = 1600;
  localparam int unsigned MixLength     = 40;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffAfter  = 300;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 8;

  // Operation and register codes that the block does not decode.
  localparam logic [OpW-1:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [OpW-1:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [SelW-1:0] REG_NONE       = 3'd7;

  // Stimulus mixes and receiver stall patterns.
  typedef enum logic [1:0] {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;
  typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [5:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;

  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned cycle_count;

  audio_codec_fifo_register_block_core #(
    .ADC_FIFO_DEPTH(FifoDepth),
    .DAC_FIFO_DEPTH(FifoDepth)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  acfrb_codec_word_chk #(
    .ADC_DEPTH(FifoDepth),
    .DAC_DEPTH(FifoDepth)
  ) word_chk (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .fail_count(fail_count),
    .words_pending(words_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one word; a new burst starts after a random gap.
  task automatic send_word(input logic [OpW-1:0] op, input logic [SelW-1:0] sel,
                           input logic [DataW-1:0] wv, input logic [DataW-1:0] smp);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {smp, wv};
    s_tuser  <= {sel, op};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Choose a random access; fill and drain mixes drive the FIFOs to their limits.
  task automatic pick_word(input mix_t mix, output logic [OpW-1:0] op,
                           output logic [SelW-1:0] sel, output logic [DataW-1:0] wv,
                           output logic [DataW-1:0] smp);
    int unsigned r;
    wv  = DataW'($urandom);
    smp = DataW'($urandom);
    sel = SelW'($urandom_range(0, 7));
    r   = $urandom_range(0, 99);
    if (mix == MIX_FILL && r < 80) begin
      if (r < 40) begin
        op = OP_ADC_PUSH;
      end else begin
        op  = OP_BUS_WRITE;
        sel = REG_DAC_DATA;
      end
    end else if (mix == MIX_DRAIN && r < 80) begin
      if (r < 40) begin
        op  = OP_BUS_READ;
        sel = REG_ADC_DATA;
      end else begin
        op = OP_DAC_PULL;
      end
    end else begin
      r = $urandom_range(0, 99);
      if (r < 20) op = OP_BUS_READ;
      else if (r < 32) op = OP_BUS_WRITE;
      else if (r < 46) op = OP_ADC_PUSH;
      else if (r < 60) op = OP_DAC_PULL;
      else if (r < 72) begin
        op  = OP_BUS_WRITE;
        sel = REG_DAC_DATA;
      end else if (r < 84) begin
        op  = OP_BUS_READ;
        sel = REG_ADC_DATA;
      end else if (r < 88) op = OP_OVERCURR;
      else if (r < 93) begin
        op  = OP_BUS_WRITE;
        sel = REG_FLAGS;
      end else if (r < 96) op = OpW'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else begin
        op  = OP_BUS_READ;
        sel = REG_FLAGS;
      end
    end
    // Keep both channels powered most of the time so the FIFOs see traffic.
    if (op == OP_BUS_WRITE && sel == REG_POWER && $urandom_range(0, 3) != 0) wv[1:0] = 2'b11;
  endtask

  // Reset, directed words, random words, then drain and verdict.
  initial begin
    logic [OpW-1:0]   op;
    logic [SelW-1:0]  sel;
    logic [DataW-1:0] wv;
    logic [DataW-1:0] smp;
    mix_t             mix;
    mix = MIX_BALANCED;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Register widths, FIFO order and empty cases, sticky flags and their clearing.
    send_word(OP_BUS_READ, REG_POWER, '0, '0);
    send_word(OP_BUS_READ, REG_FLAGS, '0, '0);
    send_word(OP_BUS_WRITE, REG_MASK, 16'hFFFF, '0);
    send_word(OP_BUS_WRITE, REG_POWER, 16'hFFFF, '0);
    send_word(OP_BUS_WRITE, REG_ADC_CTL, 16'hFFFF, '0);
    send_word(OP_BUS_READ, REG_ADC_CTL, '0, '0);
    send_word(OP_BUS_WRITE, REG_DAC_CTL, 16'hFFFF, '0);
    send_word(OP_BUS_READ, REG_DAC_CTL, '0, '0);
    send_word(OP_ADC_PUSH, REG_NONE, '0, 16'h8000);
    send_word(OP_ADC_PUSH, REG_NONE, '0, 16'h7FFF);
    send_word(OP_BUS_READ, REG_ADC_DATA, '0, '0);
    send_word(OP_BUS_READ, REG_ADC_DATA, '0, '0);
    send_word(OP_BUS_READ, REG_ADC_DATA, '0, '0);
    send_word(OP_DAC_PULL, REG_POWER, '0, '0);
    send_word(OP_BUS_WRITE, REG_DAC_DATA, 16'hFFFF, '0);
    send_word(OP_DAC_PULL, REG_POWER, '0, '0);
    send_word(OP_OVERCURR, REG_POWER, '0, '0);
    send_word(OP_BUS_READ, REG_FLAGS, '0, '0);
    send_word(OP_BUS_WRITE, REG_FLAGS, 16'hFFFF, '0);
    send_word(OP_BUS_READ, REG_DAC_DATA, '0, '0);
    send_word(OP_BUS_WRITE, REG_ADC_DATA, 16'hFFFF, '0);
    send_word(OP_BUS_READ, REG_NONE, '0, '0);
    send_word(OP_BUS_WRITE, REG_NONE, 16'hFFFF, '0);
    send_word(OP_SPARE_FIRST, REG_POWER, '0, '0);
    send_word(OP_SPARE_LAST, REG_NONE, 16'hFFFF, 16'hFFFF);
    // Powered-down channels ignore converter events.
    send_word(OP_BUS_WRITE, REG_POWER, '0, '0);
    send_word(OP_ADC_PUSH, REG_POWER, '0, 16'h1234);
    send_word(OP_DAC_PULL, REG_POWER, '0, '0);
    send_word(OP_BUS_WRITE, REG_POWER, 16'h0007, '0);

    for (int unsigned i = 0; i < RandomWords; i++) begin
      if (i % MixLength == 0) mix = mix_t'($urandom_range(0, 2));
      pick_word(mix, op, sel, wv, smp);
      send_word(op, sel, wv, smp);
    end
    s_tvalid <= 1'b0;

    // The count seen after the next edge includes the last accepted word.
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Receiver stalls: changing patterns, plus one long hold-off that backs up the block.
  initial begin
    rx_pattern_t pattern;
    int unsigned pattern_left;
    bit          held;
    pattern      = RX_STEADY;
    pattern_left = 0;
    held         = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_sent >= HoldOffAfter) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      if (pattern_left == 0) begin
        pattern      = rx_pattern_t'($urandom_range(0, 2));
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      case (pattern)
        RX_STEADY: m_tready <= 1'b1;
        RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
        default:   m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
